[sv/fcna_pkg.sv]
package fcna_pkg;

    localparam int LEN_BITS_DEF = 10;
    localparam int VALUE_W      = 10;
    localparam int BYTE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int CRC_W        = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    typedef enum logic [1:0] {
        OP_FRAME_START  = 2'd0,
        OP_PAYLOAD_BYTE = 2'd1,
        OP_DATA_NIBBLE  = 2'd2
    } op_t;

    // core -> output sequencer
    typedef struct packed {
        logic             valid;
        logic [NIB_W-1:0] nib;
        logic             append;
        logic [CRC_W-1:0] crc;
    } result_t;

    // output sequencer -> top
    typedef struct packed {
        logic buf_free;
        logic crc_pending;
    } out_status_t;

    // one byte, MSB first
    function automatic logic [CRC_W-1:0] crc16_feed_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] byte_in
    );
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] b;
        logic              fb;
        c = crc_in;
        b = byte_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb = c[CRC_W-1] ^ b[BYTE_W-1];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            b = {b[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/fcna_core.sv]
module fcna_core #(
    parameter int LEN_BITS = fcna_pkg::LEN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [1:0]                   op,
    input  logic [fcna_pkg::VALUE_W-1:0] value,
    input  logic                         crc_enable,
    output fcna_pkg::result_t            res
);

    logic [fcna_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic [fcna_pkg::BYTE_W-1:0] held0_reg, held0_next;
    logic [fcna_pkg::BYTE_W-1:0] held1_reg, held1_next;
    logic [1:0]                  hcnt_reg,  hcnt_next;
    logic [LEN_BITS-1:0]         flen_reg,  flen_next;
    logic [LEN_BITS-1:0]         ncnt_reg,  ncnt_next;
    logic [LEN_BITS-1:0]         ncnt_inc;

    assign ncnt_inc = ncnt_reg + LEN_BITS'(1);

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        hcnt_next  = hcnt_reg;
        flen_next  = flen_reg;
        ncnt_next  = ncnt_reg;
        res        = '0;
        if (fire)
        begin
            unique case (op)
                fcna_pkg::OP_FRAME_START:
                begin
                    crc_next   = fcna_pkg::CRC_INIT;
                    held0_next = '0;
                    held1_next = '0;
                    hcnt_next  = 2'd0;
                    flen_next  = LEN_BITS'(value);
                    ncnt_next  = '0;
                end
                fcna_pkg::OP_PAYLOAD_BYTE:
                begin
                    if (hcnt_reg[1])
                    begin
                        crc_next = fcna_pkg::crc16_feed_byte(crc_reg, held0_reg);
                    end
                    held0_next = held1_reg;
                    held1_next = value[fcna_pkg::BYTE_W-1:0];
                    if (!hcnt_reg[1])
                    begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
                fcna_pkg::OP_DATA_NIBBLE:
                begin
                    ncnt_next = ncnt_inc;
                    res.valid = 1'b1;
                    res.nib   = value[fcna_pkg::NIB_W-1:0];
                    if (crc_enable && (ncnt_inc == flen_reg))
                    begin
                        res.append = 1'b1;
                        res.crc    = crc_reg ^ {held0_reg, held1_reg};
                        crc_next   = fcna_pkg::CRC_INIT;
                        held0_next = '0;
                        held1_next = '0;
                        hcnt_next  = 2'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= fcna_pkg::CRC_INIT;
            held0_reg <= '0;
            held1_reg <= '0;
            hcnt_reg  <= 2'd0;
            flen_reg  <= '0;
            ncnt_reg  <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            hcnt_reg  <= hcnt_next;
            flen_reg  <= flen_next;
            ncnt_reg  <= ncnt_next;
        end
    end

endmodule

[sv/fcna_out.sv]
module fcna_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcna_pkg::result_t             res,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [fcna_pkg::NIB_W-1:0]    nibble,
    output logic                          is_crc,
    output logic                          last,
    output fcna_pkg::out_status_t         status
);

    logic                        valid_reg, valid_next;
    logic [fcna_pkg::NIB_W-1:0]  nib_reg,   nib_next;
    logic                        crc_reg,   crc_next;
    logic                        last_reg,  last_next;
    logic [fcna_pkg::CRC_W-1:0]  sh_reg,    sh_next;
    logic [2:0]                  left_reg,  left_next;
    logic                        beat;

    assign beat            = valid_reg && !out_stall;
    assign status.buf_free = !valid_reg || (beat && (left_reg == 3'd0));
    assign status.crc_pending = (left_reg != 3'd0);

    always_comb
    begin
        valid_next = valid_reg;
        nib_next   = nib_reg;
        crc_next   = crc_reg;
        last_next  = last_reg;
        sh_next    = sh_reg;
        left_next  = left_reg;
        if (beat)
        begin
            if (left_reg != 3'd0)
            begin
                nib_next  = sh_reg[fcna_pkg::NIB_W-1:0];
                sh_next   = sh_reg >> fcna_pkg::NIB_W;
                crc_next  = 1'b1;
                last_next = (left_reg == 3'd1);
                left_next = left_reg - 3'd1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        if (res.valid)
        begin
            valid_next = 1'b1;
            nib_next   = res.nib;
            crc_next   = 1'b0;
            last_next  = !res.append;
            sh_next    = res.crc;
            left_next  = res.append ? 3'd4 : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_reg  <= nib_next;
        crc_reg  <= crc_next;
        last_reg <= last_next;
        sh_reg   <= sh_next;
    end

    assign out_valid = valid_reg;
    assign nibble    = nib_reg;
    assign is_crc    = crc_reg;
    assign last      = last_reg;

endmodule

[sv/frame_crc16_nibble_appender_top.sv]
// Frame CRC-16 nibble appender.
// Input channel (in_valid/in_stall, op, value): frame start loads the length
// in nibbles, payload bytes feed a CRC-16 (poly 0x1021, init 0) two bytes
// behind, data nibbles pass through. Output channel (out_valid/out_stall,
// nibble, is_crc, last): one beat per data nibble; when the nibble count hits
// the frame length with crc_enable set, four CRC nibbles follow, lowest
// first, last on the final one.
// Config channel (cfg_valid/cfg_ready, cfg_data): crc_enable, always ready,
// write only while idle.
// An input beat reaches the output through the input register, then the result
// register. Throughput: one item per cycle while nothing stalls; an item that
// appends CRC holds the output for five beats, during which a following
// data nibble waits in the input register; frame-start and payload-byte
// items still pass.
// Reset: frame state cleared, crc_enable set, both channels empty.
// Output stall: output beat held; input stalls once the input register
// holds a data nibble that cannot enter the result register.
module frame_crc16_nibble_appender_top #(
    parameter int LEN_BITS = fcna_pkg::LEN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [fcna_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fcna_pkg::NIB_W-1:0]   nibble,
    output logic                         is_crc,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data
);

    logic                         ival_reg, ival_next;
    logic [1:0]                   iop_reg;
    logic [fcna_pkg::VALUE_W-1:0] ivalue_reg;
    logic                         crc_en_reg;
    logic                         fire;
    logic                         accept;
    fcna_pkg::result_t            res;
    fcna_pkg::out_status_t        ostat;

    assign fire = ival_reg &&
                  (ostat.buf_free || (iop_reg != fcna_pkg::OP_DATA_NIBBLE));
    assign in_stall  = ival_reg && !fire;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ival_next = ival_reg;
        if (accept)
        begin
            ival_next = 1'b1;
        end
        else if (fire)
        begin
            ival_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ival_reg   <= 1'b0;
            crc_en_reg <= 1'b1;
        end
        else
        begin
            ival_reg <= ival_next;
            if (cfg_valid && cfg_ready)
            begin
                crc_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            iop_reg    <= op;
            ivalue_reg <= value;
        end
    end

    fcna_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (iop_reg),
        .value      (ivalue_reg),
        .crc_enable (crc_en_reg),
        .res        (res)
    );

    fcna_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .nibble    (nibble),
        .is_crc    (is_crc),
        .last      (last),
        .status    (ostat)
    );

`ifndef SYNTHESIS
    a_res_into_free_buf: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ostat.buf_free)
        else $error("result produced while output buffer busy");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a CRC burst");

    a_crc_follows_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_crc && !last && !out_stall) |=> (out_valid && is_crc))
        else $error("CRC burst cut short");

    a_last_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> !ostat.crc_pending)
        else $error("last beat with CRC nibbles still pending");
`endif

endmodule

[sim/frame_crc16_nibble_appender_checker.sv]
`timescale 1ns / 100ps

module frame_crc16_nibble_appender_checker #(
    parameter int LEN_BITS = fcna_pkg::LEN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [fcna_pkg::VALUE_W-1:0] value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [fcna_pkg::NIB_W-1:0]   nibble,
    input  logic                         is_crc,
    input  logic                         last,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         cfg_data,
    output int                           beats_due,
    output int                           fails
);

    typedef struct packed {
        logic [fcna_pkg::NIB_W-1:0] nib;
        logic                       is_crc;
        logic                       last;
    } nib_beat_t;

    nib_beat_t due_q[$];

    logic                          crc_on;
    logic [fcna_pkg::CRC_W-1:0]    crc_acc;
    logic [fcna_pkg::BYTE_W-1:0]   held_prev;
    logic [fcna_pkg::BYTE_W-1:0]   held_last;
    logic [1:0]                    held_cnt;
    logic [LEN_BITS-1:0]           frame_nibs;
    logic [LEN_BITS-1:0]           nib_cnt;

    function automatic logic [fcna_pkg::CRC_W-1:0] xmodem_byte(
        input logic [fcna_pkg::CRC_W-1:0]  c,
        input logic [fcna_pkg::BYTE_W-1:0] b
    );
        logic [fcna_pkg::CRC_W-1:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < fcna_pkg::BYTE_W; i++)
        begin
            r = r[fcna_pkg::CRC_W-1] ? ((r << 1) ^ fcna_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic clear_frame();
        crc_acc   = fcna_pkg::CRC_INIT;
        held_prev = '0;
        held_last = '0;
        held_cnt  = '0;
    endtask

    task automatic push_beat(input logic [fcna_pkg::NIB_W-1:0] n, input logic c,
                             input logic l);
        nib_beat_t b;
        b.nib    = n;
        b.is_crc = c;
        b.last   = l;
        due_q.push_back(b);
    endtask

    task automatic predict_item(input logic [1:0] o,
                                input logic [fcna_pkg::VALUE_W-1:0] v);
        logic [fcna_pkg::CRC_W-1:0] fcs;
        case (o)
            fcna_pkg::OP_FRAME_START:
            begin
                clear_frame();
                frame_nibs = LEN_BITS'(v);
                nib_cnt    = '0;
            end
            fcna_pkg::OP_PAYLOAD_BYTE:
            begin
                // a byte is fed in only once two newer ones have arrived
                if (held_cnt == 2'd2)
                begin
                    crc_acc = xmodem_byte(crc_acc, held_prev);
                end
                held_prev = held_last;
                held_last = v[fcna_pkg::BYTE_W-1:0];
                if (held_cnt < 2'd2)
                begin
                    held_cnt = held_cnt + 2'd1;
                end
            end
            fcna_pkg::OP_DATA_NIBBLE:
            begin
                nib_cnt = nib_cnt + 1'b1;
                if (crc_on && nib_cnt == frame_nibs)
                begin
                    fcs = crc_acc ^ {held_prev, held_last};
                    push_beat(v[fcna_pkg::NIB_W-1:0], 1'b0, 1'b0);
                    push_beat(fcs[3:0],   1'b1, 1'b0);
                    push_beat(fcs[7:4],   1'b1, 1'b0);
                    push_beat(fcs[11:8],  1'b1, 1'b0);
                    push_beat(fcs[15:12], 1'b1, 1'b1);
                    clear_frame();
                end
                else
                begin
                    push_beat(v[fcna_pkg::NIB_W-1:0], 1'b0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_beat();
        nib_beat_t e;
        if (due_q.size() == 0)
        begin
            $error("unexpected beat: nibble %0h is_crc %0b last %0b", nibble, is_crc, last);
            fails++;
        end
        else
        begin
            e = due_q.pop_front();
            if (nibble !== e.nib)
            begin
                $error("nibble: expected %0h, got %0h", e.nib, nibble);
                fails++;
            end
            if (is_crc !== e.is_crc)
            begin
                $error("is_crc: expected %0b, got %0b", e.is_crc, is_crc);
                fails++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0b, got %0b", e.last, last);
                fails++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_on = 1'b1;
            clear_frame();
            frame_nibs = '0;
            nib_cnt    = '0;
            due_q.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                crc_on = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                predict_item(op, value);
            end
            if (out_valid && !out_stall)
            begin
                check_beat();
            end
        end
        beats_due = due_q.size();
    end

endmodule

[sim/tb_frame_crc16_nibble_appender_top.sv]
`timescale 1ns / 100ps

module tb_frame_crc16_nibble_appender_top;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         TIMEOUT_CYCLES = 800000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   op;
    logic [fcna_pkg::VALUE_W-1:0] value;
    logic                         out_valid;
    logic                         out_stall;
    logic [fcna_pkg::NIB_W-1:0]   nibble;
    logic                         is_crc;
    logic                         last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_data;

    int beats_due;
    int fails;
    int n_sent = 0;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    frame_crc16_nibble_appender_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .nibble    (nibble),
        .is_crc    (is_crc),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frame_crc16_nibble_appender_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .nibble    (nibble),
        .is_crc    (is_crc),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .beats_due (beats_due),
        .fails     (fails)
    );

    task automatic send_item(input logic [1:0] o, input logic [fcna_pkg::VALUE_W-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    // wait for every beat due, then let any item with no result work through
    task automatic settle();
        in_valid <= 1'b0;
        while (beats_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_crc_enable(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frame();
        logic [fcna_pkg::VALUE_W-1:0] len;
        int shape;
        int n_nib;
        int n_byte;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            len = fcna_pkg::VALUE_W'($urandom_range(0, 1023));
        end
        else
        begin
            len = fcna_pkg::VALUE_W'($urandom_range(1, 10));
        end
        n_nib = len;
        if (shape == 0)
        begin
            n_nib = $urandom_range(0, 6);
        end
        else if (shape == 1)
        begin
            n_nib = len + $urandom_range(1, 3);
        end
        else if (shape == 2)
        begin
            n_nib = $urandom_range(0, len);
        end
        n_byte = $urandom_range(0, 6);
        send_item(fcna_pkg::OP_FRAME_START, len);
        while (n_nib + n_byte > 0)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_item(OP_UNUSED, fcna_pkg::VALUE_W'($urandom_range(0, 1023)));
            end
            if (n_byte > 0 && $urandom_range(1, n_byte + n_nib) <= n_byte)
            begin
                send_item(fcna_pkg::OP_PAYLOAD_BYTE,
                          fcna_pkg::VALUE_W'($urandom_range(0, 1023)));
                n_byte--;
            end
            else
            begin
                send_item(fcna_pkg::OP_DATA_NIBBLE,
                          fcna_pkg::VALUE_W'($urandom_range(0, 1023)));
                n_nib--;
            end
        end
    endtask

    task automatic random_run(input int n_items);
        int target;
        target = n_sent + n_items;
        while (n_sent < target) random_frame();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = fcna_pkg::OP_FRAME_START;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // CRC on from reset; upper value bits set on bytes and nibbles
        send_item(fcna_pkg::OP_FRAME_START, 10'd6);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h0FF);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h300);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h0A5);
        send_item(OP_UNUSED, 10'h3FF);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h3F0);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h00F);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h005);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h00A);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h00C);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h003);
        // no payload: both held bytes zero
        send_item(fcna_pkg::OP_FRAME_START, 10'd2);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h001);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h002);
        // one payload byte only
        send_item(fcna_pkg::OP_FRAME_START, 10'd3);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h1FF);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h004);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h008);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h00E);
        // three bytes so one enters the accumulator; count runs on past the match
        send_item(fcna_pkg::OP_FRAME_START, 10'd1);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h012);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h034);
        send_item(fcna_pkg::OP_PAYLOAD_BYTE, 10'h056);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h009);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h006);
        send_item(fcna_pkg::OP_FRAME_START, 10'h3FF);
        send_item(fcna_pkg::OP_DATA_NIBBLE, 10'h3FF);
        settle();

        write_crc_enable(1'b0);
        random_run(25);
        settle();
        write_crc_enable(1'b1);
        random_run(35);
        settle();
        write_crc_enable(1'b0);
        random_run(15);
        settle();
        write_crc_enable(1'b1);

        idle_on = 1'b0;
        random_run(12);
        // zero length: no match before the count wraps
        send_item(fcna_pkg::OP_FRAME_START, 10'd0);
        repeat (8) send_item(fcna_pkg::OP_DATA_NIBBLE,
                             fcna_pkg::VALUE_W'($urandom_range(0, 1023)));
        settle();

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
